/* sv/rsd_pkg.sv */
// ----------------------------------------------------------------------------
// rsd_pkg: shared constants and types for the radial stick dead zone
// Widths of the stick fields, register reset value and per-stage side data.
// ----------------------------------------------------------------------------
package rsd_pkg;

  localparam int SAMPLE_SCALE_DEF = 32768;
  localparam logic [14:0] DZ_RESET = 15'd6554;

  // Stick data riding along the front of the pipeline
  typedef struct packed {
    logic        pad;
    logic        negx;
    logic        negy;
    logic [15:0] ax;
    logic [15:0] ay;
  } side_t;

  // Item state through the length divider
  typedef struct packed {
    logic        zero;
    logic        sat;
    logic        ovf;
    logic [15:0] mag;
    logic [15:0] den;
    logic        negx;
    logic        negy;
    logic [15:0] ax;
    logic [15:0] ay;
  } info_t;

  // Item state through the axis dividers
  typedef struct packed {
    logic        zero;
    logic        negx;
    logic        negy;
    logic [15:0] mag;
  } axis_t;

endpackage

/* sv/radial_stick_deadzone_top.sv */
// Pipeline: input accept to result valid runs through input, square, sum,
//   16 root stages, scale, overflow check, 17 divide stages, clamp, products,
//   overflow check, 16 divide stages, output.
// Throughput: one item per cycle; the whole pipeline stalls together when the
//   output register is full and not taken.
// Reset: synchronous active-low rst_n clears all valid bits and loads dead_zone
//   with 6554.
// ----------------------------------------------------------------------------
// radial_stick_deadzone_top
// Radial dead zone with rescale for one thumbstick, fully pipelined.
// ----------------------------------------------------------------------------
module radial_stick_deadzone_top #(
  parameter int SAMPLE_SCALE = rsd_pkg::SAMPLE_SCALE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [14:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_raw_x,
  input  logic signed [15:0] in_raw_y,
  input  logic               in_pad_connected,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y
);
  import rsd_pkg::*;

  localparam logic [16:0] SCALE17 = 17'(SAMPLE_SCALE);

  logic        en;
  logic [14:0] dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r <= DZ_RESET;
    end else if (cfg_we) begin
      dz_r <= cfg_wdata;
    end
  end

  assign en       = out_ready || !out_valid;
  assign in_ready = en;

  // ---------------- stage A: magnitudes ----------------
  logic  a_vld_r;
  side_t a_sd_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_sd_r.pad  <= in_pad_connected;
      a_sd_r.negx <= in_raw_x[15];
      a_sd_r.negy <= in_raw_y[15];
      a_sd_r.ax   <= in_raw_x[15] ? 16'(-in_raw_x) : in_raw_x;
      a_sd_r.ay   <= in_raw_y[15] ? 16'(-in_raw_y) : in_raw_y;
    end
  end

  // ---------------- stage B: squares ----------------
  logic        b_vld_r;
  side_t       b_sd_r;
  logic [31:0] b_sqx_r, b_sqy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b_sd_r  <= a_sd_r;
      b_sqx_r <= a_sd_r.ax * a_sd_r.ax;
      b_sqy_r <= a_sd_r.ay * a_sd_r.ay;
    end
  end

  // ---------------- root: one result bit per stage ----------------
  logic        sq_vld_r  [0:16];
  side_t       sq_sd_r   [0:16];
  logic [31:0] sq_rem_r  [0:16];
  logic [15:0] sq_root_r [0:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else if (en) begin
      sq_vld_r[0] <= b_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sq_sd_r[0]   <= b_sd_r;
      sq_rem_r[0]  <= b_sqx_r + b_sqy_r;
      sq_root_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < 16; k++) begin : g_sqrt
    localparam int B = 15 - k;
    logic [33:0] trial;
    assign trial = ({18'd0, sq_root_r[k]} << (B + 1)) + (34'd1 << (2 * B));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_vld_r[k+1] <= sq_vld_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_sd_r[k+1] <= sq_sd_r[k];
        if ({2'b00, sq_rem_r[k]} >= trial) begin
          sq_rem_r[k+1]  <= sq_rem_r[k] - trial[31:0];
          sq_root_r[k+1] <= sq_root_r[k] | (16'd1 << B);
        end else begin
          sq_rem_r[k+1]  <= sq_rem_r[k];
          sq_root_r[k+1] <= sq_root_r[k];
        end
      end
    end
  end

  // ---------------- stage D: dead zone test and numerator ----------------
  logic        d_vld_r;
  info_t       d_inf_r;
  logic [31:0] d_num_r;
  logic [15:0] mag;
  logic        zero_nxt, sat_nxt;
  logic [32:0] num_nxt;

  assign mag      = sq_root_r[16];
  assign zero_nxt = !sq_sd_r[16].pad || (mag == 16'd0) || (mag < {1'b0, dz_r});
  assign sat_nxt  = {2'b00, dz_r} >= SCALE17;
  assign num_nxt  = (mag - {1'b0, dz_r}) * SCALE17;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= sq_vld_r[16];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d_inf_r.zero <= zero_nxt;
      d_inf_r.sat  <= sat_nxt;
      d_inf_r.ovf  <= 1'b0;
      d_inf_r.mag  <= mag;
      d_inf_r.den  <= sat_nxt ? 16'd1 : 16'(SCALE17 - {2'b00, dz_r});
      d_inf_r.negx <= sq_sd_r[16].negx;
      d_inf_r.negy <= sq_sd_r[16].negy;
      d_inf_r.ax   <= sq_sd_r[16].ax;
      d_inf_r.ay   <= sq_sd_r[16].ay;
      d_num_r      <= (zero_nxt || sat_nxt) ? 32'd0 : num_nxt[31:0];
    end
  end

  // ---------------- length divider: overflow check, then 17 bits ----------------
  logic        dv_vld_r [0:17];
  info_t       dv_inf_r [0:17];
  logic [31:0] dv_rem_r [0:17];
  logic [16:0] dv_q_r   [0:17];
  info_t       dv_inf_nxt;

  // flag quotients that do not fit in 17 bits
  always_comb begin
    dv_inf_nxt     = d_inf_r;
    dv_inf_nxt.ovf = {1'b0, d_num_r} >= {d_inf_r.den, 17'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (en) begin
      dv_vld_r[0] <= d_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dv_inf_r[0] <= dv_inf_nxt;
      dv_rem_r[0] <= d_num_r;
      dv_q_r[0]   <= '0;
    end
  end

  for (genvar j = 0; j < 17; j++) begin : g_div
    localparam int B = 16 - j;
    logic [32:0] dsh;
    assign dsh = {17'd0, dv_inf_r[j].den} << B;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_vld_r[j+1] <= dv_vld_r[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_inf_r[j+1] <= dv_inf_r[j];
        if ({1'b0, dv_rem_r[j]} >= dsh) begin
          dv_rem_r[j+1] <= dv_rem_r[j] - dsh[31:0];
          dv_q_r[j+1]   <= dv_q_r[j] | (17'd1 << B);
        end else begin
          dv_rem_r[j+1] <= dv_rem_r[j];
          dv_q_r[j+1]   <= dv_q_r[j];
        end
      end
    end
  end

  // ---------------- stage F: clamp scaled length ----------------
  logic        f_vld_r;
  info_t       f_inf_r;
  logic [15:0] f_sc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= dv_vld_r[17];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      f_inf_r <= dv_inf_r[17];
      if (dv_inf_r[17].sat || dv_inf_r[17].ovf || (dv_q_r[17] > SCALE17)) begin
        f_sc_r <= SCALE17[15:0];
      end else begin
        f_sc_r <= dv_q_r[17][15:0];
      end
    end
  end

  // ---------------- stage G: axis products ----------------
  logic        g_vld_r;
  axis_t       g_ax_r;
  logic [31:0] g_px_r, g_py_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else if (en) begin
      g_vld_r <= f_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      g_ax_r.zero <= f_inf_r.zero;
      g_ax_r.negx <= f_inf_r.negx;
      g_ax_r.negy <= f_inf_r.negy;
      g_ax_r.mag  <= f_inf_r.mag;
      g_px_r      <= f_inf_r.ax * f_sc_r;
      g_py_r      <= f_inf_r.ay * f_sc_r;
    end
  end

  // ---------------- axis dividers: overflow check, then 16 bits ----------------
  logic        ad_vld_r  [0:16];
  axis_t       ad_ax_r   [0:16];
  logic        ad_ovx_r  [0:16];
  logic        ad_ovy_r  [0:16];
  logic [31:0] ad_remx_r [0:16];
  logic [31:0] ad_remy_r [0:16];
  logic [15:0] ad_qx_r   [0:16];
  logic [15:0] ad_qy_r   [0:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ad_vld_r[0] <= 1'b0;
    end else if (en) begin
      ad_vld_r[0] <= g_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ad_ax_r[0]   <= g_ax_r;
      ad_ovx_r[0]  <= g_px_r >= {g_ax_r.mag, 16'd0};
      ad_ovy_r[0]  <= g_py_r >= {g_ax_r.mag, 16'd0};
      ad_remx_r[0] <= g_px_r;
      ad_remy_r[0] <= g_py_r;
      ad_qx_r[0]   <= '0;
      ad_qy_r[0]   <= '0;
    end
  end

  for (genvar k = 0; k < 16; k++) begin : g_axdiv
    localparam int B = 15 - k;
    logic [31:0] msh;
    assign msh = {16'd0, ad_ax_r[k].mag} << B;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ad_vld_r[k+1] <= 1'b0;
      end else if (en) begin
        ad_vld_r[k+1] <= ad_vld_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ad_ax_r[k+1]  <= ad_ax_r[k];
        ad_ovx_r[k+1] <= ad_ovx_r[k];
        ad_ovy_r[k+1] <= ad_ovy_r[k];
        if (ad_remx_r[k] >= msh) begin
          ad_remx_r[k+1] <= ad_remx_r[k] - msh;
          ad_qx_r[k+1]   <= ad_qx_r[k] | (16'd1 << B);
        end else begin
          ad_remx_r[k+1] <= ad_remx_r[k];
          ad_qx_r[k+1]   <= ad_qx_r[k];
        end
        if (ad_remy_r[k] >= msh) begin
          ad_remy_r[k+1] <= ad_remy_r[k] - msh;
          ad_qy_r[k+1]   <= ad_qy_r[k] | (16'd1 << B);
        end else begin
          ad_remy_r[k+1] <= ad_remy_r[k];
          ad_qy_r[k+1]   <= ad_qy_r[k];
        end
      end
    end
  end

  // ---------------- output: sign, saturate, zero ----------------
  function automatic logic [15:0] finish_axis(logic neg, logic ovf, logic [15:0] q);
    logic [15:0] m;
    begin
      if (neg) begin
        m = (ovf || (q > 16'd32768)) ? 16'd32768 : q;
        finish_axis = ~m + 16'd1;
      end else begin
        finish_axis = (ovf || (q > 16'd32767)) ? 16'd32767 : q;
      end
    end
  endfunction

  logic out_vld_r;
  logic signed [15:0] out_x_r, out_y_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= ad_vld_r[16];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (ad_ax_r[16].zero) begin
        out_x_r <= '0;
        out_y_r <= '0;
      end else begin
        out_x_r <= finish_axis(ad_ax_r[16].negx, ad_ovx_r[16], ad_qx_r[16]);
        out_y_r <= finish_axis(ad_ax_r[16].negy, ad_ovy_r[16], ad_qy_r[16]);
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;

  // ---------------- assertions ----------------
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (out_ready || !out_valid))
    else $error("in_ready does not follow output stall");

  a_root: assert property (@(posedge clk) disable iff (!rst_n)
    sq_vld_r[16] |-> ({1'b0, sq_rem_r[16]} <= {16'd0, sq_root_r[16], 1'b0}))
    else $error("root remainder too large");

  a_scale: assert property (@(posedge clk) disable iff (!rst_n)
    f_vld_r |-> ({1'b0, f_sc_r} <= SCALE17))
    else $error("scaled length above full scale");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (en && ad_vld_r[16] && ad_ax_r[16].zero) |=> (out_x == 16'sd0 && out_y == 16'sd0))
    else $error("dead zone item gave nonzero result");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: radial stick dead zone with rescale
// Drives stick samples through the valid/ready pipeline, predicts each output
// item with a bit-accurate integer model and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;
  import rsd_pkg::*;

  localparam int SCALE      = SAMPLE_SCALE_DEF;
  localparam int LATENCY    = 58;
  localparam int CYCLE_CAP  = 400000;
  localparam int N_ROWS     = 14;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } stick_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               pad;
    logic               known;
    stick_t             want;
  } row_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [14:0] cfg_wdata;
  logic in_valid, in_ready, in_pad_connected;
  logic signed [15:0] in_raw_x, in_raw_y;
  logic out_valid, out_ready;
  logic signed [15:0] out_x, out_y;

  radial_stick_deadzone_top u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_raw_x(in_raw_x),
    .in_raw_y(in_raw_y), .in_pad_connected(in_pad_connected),
    .out_valid(out_valid), .out_ready(out_ready), .out_x(out_x), .out_y(out_y)
  );

  logic [14:0] dz_shadow;
  stick_t      pending_sticks[$];
  int          mismatches, outputs_seen, cycles;
  bit          quiet_phase, hold_off;
  int          hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] int_sqrt(input logic [31:0] n);
    logic [31:0] res, bitv;
    res  = 0;
    bitv = 32'h4000_0000;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] scale_axis(input logic signed [15:0] v,
                                             input logic [31:0] scaled,
                                             input logic [31:0] mag);
    logic [31:0] a;
    logic [63:0] q;
    a = v[15] ? 32'(-32'(v)) : 32'(v);
    q = (64'(a) * 64'(scaled)) / 64'(mag);
    if (v[15]) begin
      if (q > 32768) q = 32768;
      return 16'(17'h10000 - 17'(q));
    end
    if (q > 32767) q = 32767;
    return q[15:0];
  endfunction

  function automatic stick_t rescale_stick(input logic signed [15:0] x,
                                           input logic signed [15:0] y,
                                           input logic pad,
                                           input logic [14:0] dz);
    logic [31:0] ax, ay, mag, scaled;
    logic [63:0] s;
    stick_t r;
    r  = '0;
    ax = x[15] ? 32'(-32'(x)) : 32'(x);
    ay = y[15] ? 32'(-32'(y)) : 32'(y);
    mag = int_sqrt(ax * ax + ay * ay);
    if (!pad || mag == 0 || mag < 32'(dz)) return r;
    s = (64'(mag - 32'(dz)) * SCALE) / 64'(SCALE - 32'(dz));
    scaled = (s > SCALE) ? SCALE : s[31:0];
    r.x = scale_axis(x, scaled, mag);
    r.y = scale_axis(y, scaled, mag);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH item %0d %s: got %0d expected %0d", outputs_seen, what, got, want);
    mismatches++;
  endtask

  // Output side: random stalls, one long hold while the sender keeps offering
  initial begin
    int burst;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        for (hold_cycles = 0; hold_cycles < 200; hold_cycles++) @(posedge clk);
        hold_off = 0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 9);
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare accepted output items against the oldest prediction
  always @(posedge clk) begin
    stick_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_sticks.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        want = pending_sticks.pop_front();
        if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
        if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
      end
      outputs_seen++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_item(input logic signed [15:0] x, input logic signed [15:0] y,
                           input logic pad);
    stick_t pred;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_raw_x         <= x;
    in_raw_y         <= y;
    in_pad_connected <= pad;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = rescale_stick(x, y, pad, dz_shadow);
    pending_sticks.insert(pending_sticks.size(), pred);
  endtask

  task automatic drain_and_write(input logic [14:0] dz);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_sticks.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= dz;
    @(posedge clk);
    cfg_we    <= 1'b0;
    dz_shadow = dz;
  endtask

  task automatic random_phase(input int count);
    logic signed [15:0] x, y;
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 9);
      x = 16'($urandom);
      y = 16'($urandom);
      // bias toward small deflections near the dead zone edge
      if (kind < 3) begin
        x = $signed(16'($urandom_range(0, 2 * int'(dz_shadow) + 64))) - 16'(dz_shadow);
        y = $signed(16'($urandom_range(0, 2 * int'(dz_shadow) + 64))) - 16'(dz_shadow);
      end else if (kind == 3) begin
        y = '0;
      end
      send_item(x, y, $urandom_range(0, 7) != 0);
    end
  endtask

  row_t directed [0:N_ROWS-1];

  function automatic row_t mk(input int x, input int y, input logic pad,
                              input logic known, input int wx, input int wy);
    row_t r;
    r.x = 16'(x); r.y = 16'(y); r.pad = pad; r.known = known;
    r.want.x = 16'(wx); r.want.y = 16'(wy);
    return r;
  endfunction

  initial begin
    stick_t pred;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
    in_valid = 1'b0; in_raw_x = '0; in_raw_y = '0; in_pad_connected = 1'b0;
    mismatches = 0; outputs_seen = 0; cycles = 0;
    quiet_phase = 0; hold_off = 0;
    dz_shadow = DZ_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pad absent, zero, dead zone, full scale, corners, extremes
    directed[0]  = mk(32767, 32767, 1'b0, 1'b1, 0, 0);
    directed[1]  = mk(0, 0, 1'b1, 1'b1, 0, 0);
    directed[2]  = mk(100, -100, 1'b1, 1'b1, 0, 0);
    directed[3]  = mk(6553, 0, 1'b1, 1'b1, 0, 0);
    directed[4]  = mk(6554, 0, 1'b1, 1'b1, 0, 0);
    directed[5]  = mk(32767, 0, 1'b1, 1'b0, 0, 0);
    directed[6]  = mk(-32768, 0, 1'b1, 1'b0, 0, 0);
    directed[7]  = mk(0, -32768, 1'b1, 1'b0, 0, 0);
    directed[8]  = mk(-32768, -32768, 1'b1, 1'b0, 0, 0);
    directed[9]  = mk(32767, 32767, 1'b1, 1'b0, 0, 0);
    directed[10] = mk(-32768, 32767, 1'b1, 1'b0, 0, 0);
    directed[11] = mk(20000, -15000, 1'b1, 1'b0, 0, 0);
    directed[12] = mk(-1, 1, 1'b1, 1'b1, 0, 0);
    directed[13] = mk(16'h5555, 16'hAAAA, 1'b1, 1'b0, 0, 0);
    foreach (directed[i]) begin
      send_item(directed[i].x, directed[i].y, directed[i].pad);
      if (directed[i].known) begin
        pred = pending_sticks[pending_sticks.size() - 1];
        if (pred != directed[i].want)
          report_mismatch("table row", i, -1);
      end
    end

    random_phase(150);
    drain_and_write(15'd0);
    // zero dead zone: mag one already rescales
    send_item(1, 0, 1'b1);
    send_item(-32768, -32768, 1'b1);
    hold_off = 1;
    random_phase(150);
    drain_and_write(15'h7FFF);
    send_item(-32768, 0, 1'b1);
    send_item(32767, 32767, 1'b1);
    random_phase(100);
    drain_and_write(15'h2AAA);
    random_phase(150);
    drain_and_write(15'h5555);
    quiet_phase = 1;
    random_phase(200);

    in_valid <= 1'b0;
    while (pending_sticks.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d output items over dead zone reset, 0, 0x7fff, 0x2aaa, 0x5555,",
             outputs_seen);
    $display("with random stalls on both sides and one long output hold");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
sv/rsd_pkg.sv
sv/radial_stick_deadzone_top.sv
test/testbench.sv
